// File: design/assert_macros.svh
// Assertion helpers, included by gpn_front
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on the rising clock, off during reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that also holds while reset is asserted
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: design/gpn_pkg.sv
// ----------------------------------------------------------------------------
// gpn_pkg
// Types, constants and helpers of the gradient noise core.
// ----------------------------------------------------------------------------
package gpn_pkg;

   localparam int TableEntries = 1024;
   localparam int AddrW        = $clog2(TableEntries);
   localparam int QDepth       = 4;
   localparam int QPtrW        = $clog2(QDepth);
   localparam int QCntW        = $clog2(QDepth + 1);

   localparam logic [1:0] KIND_HASH = 2'd0;
   localparam logic [1:0] KIND_GRAD = 2'd1;
   localparam logic [1:0] KIND_EVAL = 2'd2;

   localparam logic [2:0] CSR_ORIGIN_U  = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_V  = 3'd1;
   localparam logic [2:0] CSR_STEP_U    = 3'd2;
   localparam logic [2:0] CSR_STEP_V    = 3'd3;
   localparam logic [2:0] CSR_AMPLITUDE = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE = 4'b0001,
      OP_HASH = 4'b0010,
      OP_GRAD = 4'b0100,
      OP_EVAL = 4'b1000
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  table_index;
      logic [9:0]  table_value;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] raw_noise;
      logic signed [19:0] scaled_noise;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [9:0]  idx;
      logic [9:0]  val;
      logic [15:0] px;
      logic [15:0] py;
   } cmd_type;

   typedef struct packed {
      logic [31:0] origin_u;
      logic [31:0] origin_v;
      logic [31:0] step_u;
      logic [31:0] step_v;
      logic [15:0] amplitude;
   } cfg_type;

   // lookup results handed to the blend pipeline
   typedef struct packed {
      logic        valid;
      logic [7:0]  rx0;
      logic [7:0]  ry0;
      logic [11:0] sx;
      logic [11:0] sy;
      logic [7:0][8:0] g;  // 00a 00b 10a 10b 01a 01b 11a 11b
   } lk_type;

   // table address, wrapped to the table size
   function automatic logic [AddrW-1:0] to_addr(logic [11:0] x);
      return x[AddrW-1:0];
   endfunction

endpackage

// File: design/gpn_front.sv
// ----------------------------------------------------------------------------
// gpn_front
// Accepts request transactions, decodes the kind and queues commands.
// ----------------------------------------------------------------------------
module gpn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gpn_pkg::req_type req_data,
   input  logic             pop,
   output logic             head_valid,
   output gpn_pkg::cmd_type head
);
   import gpn_pkg::*;
`include "assert_macros.svh"

   cmd_type            q_mem [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   count_ff, count_in;
   cmd_type            cmd;
   logic               accept, push, do_pop;

   always_comb begin
      cmd.idx = req_data.table_index;
      cmd.val = req_data.table_value;
      cmd.px  = req_data.pixel_x;
      cmd.py  = req_data.pixel_y;
      unique case (req_data.kind)
         KIND_HASH: cmd.op = OP_HASH;
         KIND_GRAD: cmd.op = OP_GRAD;
         KIND_EVAL: cmd.op = OP_EVAL;
         default:   cmd.op = OP_NONE;
      endcase
   end

   assign req_ready  = (count_ff != QCntW'(QDepth));
   assign accept     = req_valid && req_ready;
   // unused kind is taken and dropped here
   assign push       = accept && (cmd.op != OP_NONE);
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;
   assign head       = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCntW'(push) - QCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cmd;
      end
   end

   `ASSERT_CLK(a_cnt_max, count_ff <= QCntW'(QDepth), "queue count above depth")
   `ASSERT_CLK(a_cnt_track, !(push || do_pop) |=> $stable(count_ff), "count moved idle")
   `ASSERT_CLK(a_no_pop_empty, pop && !head_valid |=> count_ff <= QCntW'(1), "pop of empty")

endmodule

// File: design/gpn_lookup.sv
// ----------------------------------------------------------------------------
// gpn_lookup
// Coordinate math, fade and the hash and gradient table lookups.
// Table writes travel with the stream and update each copy in read order.
// ----------------------------------------------------------------------------
module gpn_lookup (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  gpn_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  gpn_pkg::cmd_type head,
   output logic             pop,
   output gpn_pkg::lk_type  lk
);
   import gpn_pkg::*;

   logic [9:0] hash1_mem  [TableEntries];
   logic [9:0] hash2a_mem [TableEntries];
   logic [9:0] hash2b_mem [TableEntries];
   logic [8:0] grad0_mem  [TableEntries];
   logic [8:0] grad1_mem  [TableEntries];
   logic [8:0] grad2_mem  [TableEntries];
   logic [8:0] grad3_mem  [TableEntries];

   op_type      s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff, s5_op_ff;
   logic [9:0]  s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [9:0]  s1_val_ff, s2_val_ff, s3_val_ff, s4_val_ff;
   logic [17:0] s1_pu_ff, s1_pv_ff;
   logic [15:0] s2_u16_ff, s2_v16_ff;
   logic [7:0]  s3_rx_ff, s3_ry_ff, s3_by0_ff;
   logic [9:0]  s3_hx0_ff, s3_hx1_ff;
   logic [14:0] s3_rrx_ff, s3_rry_ff;
   logic [10:0] s3_kx_ff, s3_ky_ff;
   logic [7:0]  s4_rx_ff, s4_ry_ff, s5_rx_ff, s5_ry_ff;
   logic [11:0] s4_sx_ff, s4_sy_ff, s5_sx_ff, s5_sy_ff;
   logic [9:0]  s4_b00_ff, s4_b01_ff, s4_b10_ff, s4_b11_ff;
   logic [7:0][8:0] s5_g_ff;

   logic [33:0] pu_full, pv_full;
   logic [31:0] u, v;
   logic [7:0]  bx0, bx1, rx, ry, by1;
   logic [15:0] rx_sq, ry_sq;
   logic [25:0] fx_prod, fy_prod;

   assign pop     = en && head_valid;
   assign pu_full = head.px * cfg.step_u[31:14];
   assign pv_full = head.py * cfg.step_v[31:14];
   assign u       = cfg.origin_u + {s1_pu_ff, 14'b0};
   assign v       = cfg.origin_v + {s1_pv_ff, 14'b0};
   assign bx0     = s2_u16_ff[15:8];
   assign bx1     = bx0 + 8'd1;
   assign rx      = s2_u16_ff[7:0];
   assign ry      = s2_v16_ff[7:0];
   assign rx_sq   = rx * rx;
   assign ry_sq   = ry * ry;
   assign by1     = s3_by0_ff + 8'd1;
   assign fx_prod = s3_rrx_ff * s3_kx_ff;
   assign fy_prod = s3_rry_ff * s3_ky_ff;

   // op tags are control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= OP_NONE;
         s2_op_ff <= OP_NONE;
         s3_op_ff <= OP_NONE;
         s4_op_ff <= OP_NONE;
         s5_op_ff <= OP_NONE;
      end else if (en) begin
         s1_op_ff <= head_valid ? head.op : OP_NONE;
         s2_op_ff <= s1_op_ff;
         s3_op_ff <= s2_op_ff;
         s4_op_ff <= s3_op_ff;
         s5_op_ff <= s4_op_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: pixel times step
         s1_idx_ff <= head.idx;
         s1_val_ff <= head.val;
         s1_pu_ff  <= pu_full[17:0];
         s1_pv_ff  <= pv_full[17:0];
         // stage 2: 8.8 coordinates
         s2_idx_ff <= s1_idx_ff;
         s2_val_ff <= s1_val_ff;
         s2_u16_ff <= u[29:14];
         s2_v16_ff <= v[29:14];
         // stage 3: first hash level, fade operands
         if (s2_op_ff == OP_HASH) begin
            hash1_mem[to_addr({2'b0, s2_idx_ff})] <= s2_val_ff;
         end
         s3_hx0_ff <= hash1_mem[to_addr({4'b0, bx0})];
         s3_hx1_ff <= hash1_mem[to_addr({4'b0, bx1})];
         s3_idx_ff <= s2_idx_ff;
         s3_val_ff <= s2_val_ff;
         s3_rx_ff  <= rx;
         s3_ry_ff  <= ry;
         s3_by0_ff <= s2_v16_ff[15:8];
         s3_rrx_ff <= rx_sq[15:1];
         s3_rry_ff <= ry_sq[15:1];
         s3_kx_ff  <= 11'(12'd1536 - {2'b0, rx, 2'b0});
         s3_ky_ff  <= 11'(12'd1536 - {2'b0, ry, 2'b0});
         // stage 4: second hash level, fade result
         if (s3_op_ff == OP_HASH) begin
            hash2a_mem[to_addr({2'b0, s3_idx_ff})] <= s3_val_ff;
            hash2b_mem[to_addr({2'b0, s3_idx_ff})] <= s3_val_ff;
         end
         s4_b00_ff <= hash2a_mem[to_addr(12'(s3_hx0_ff) + 12'(s3_by0_ff))];
         s4_b01_ff <= hash2a_mem[to_addr(12'(s3_hx0_ff) + 12'(by1))];
         s4_b10_ff <= hash2b_mem[to_addr(12'(s3_hx1_ff) + 12'(s3_by0_ff))];
         s4_b11_ff <= hash2b_mem[to_addr(12'(s3_hx1_ff) + 12'(by1))];
         s4_idx_ff <= s3_idx_ff;
         s4_val_ff <= s3_val_ff;
         s4_rx_ff  <= s3_rx_ff;
         s4_ry_ff  <= s3_ry_ff;
         s4_sx_ff  <= fx_prod[23:12];
         s4_sy_ff  <= fy_prod[23:12];
         // stage 5: gradients
         if (s4_op_ff == OP_GRAD) begin
            grad0_mem[to_addr({2'b0, s4_idx_ff})] <= s4_val_ff[8:0];
            grad1_mem[to_addr({2'b0, s4_idx_ff})] <= s4_val_ff[8:0];
            grad2_mem[to_addr({2'b0, s4_idx_ff})] <= s4_val_ff[8:0];
            grad3_mem[to_addr({2'b0, s4_idx_ff})] <= s4_val_ff[8:0];
         end
         s5_g_ff[0] <= grad0_mem[to_addr(12'(s4_b00_ff))];
         s5_g_ff[1] <= grad0_mem[to_addr(12'(s4_b00_ff) + 12'd1)];
         s5_g_ff[2] <= grad1_mem[to_addr(12'(s4_b10_ff))];
         s5_g_ff[3] <= grad1_mem[to_addr(12'(s4_b10_ff) + 12'd1)];
         s5_g_ff[4] <= grad2_mem[to_addr(12'(s4_b01_ff))];
         s5_g_ff[5] <= grad2_mem[to_addr(12'(s4_b01_ff) + 12'd1)];
         s5_g_ff[6] <= grad3_mem[to_addr(12'(s4_b11_ff))];
         s5_g_ff[7] <= grad3_mem[to_addr(12'(s4_b11_ff) + 12'd1)];
         s5_rx_ff   <= s4_rx_ff;
         s5_ry_ff   <= s4_ry_ff;
         s5_sx_ff   <= s4_sx_ff;
         s5_sy_ff   <= s4_sy_ff;
      end
   end

   always_comb begin
      lk.valid = (s5_op_ff == OP_EVAL);
      lk.rx0   = s5_rx_ff;
      lk.ry0   = s5_ry_ff;
      lk.sx    = s5_sx_ff;
      lk.sy    = s5_sy_ff;
      lk.g     = s5_g_ff;
   end

endmodule

// File: design/gpn_blend.sv
// ----------------------------------------------------------------------------
// gpn_blend
// Gradient dot products, bilinear blend, truncation and gain.
// Owns the output register and the pipeline advance enable.
// ----------------------------------------------------------------------------
module gpn_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      amplitude,
   input  gpn_pkg::lk_type  lk,
   output logic             en,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gpn_pkg::rsp_type rsp_data
);
   import gpn_pkg::*;

   logic               v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   logic signed [21:0] s6_u1_ff, s6_v1_ff, s6_u2_ff, s6_v2_ff;
   logic [11:0]        s6_sx_ff, s6_sy_ff, s7_sy_ff, s8_sy_ff;
   logic signed [35:0] s7_m1_ff, s7_m2_ff;
   logic signed [21:0] s7_u1_ff, s7_u2_ff;
   logic signed [23:0] s8_a_ff, s8_b_ff, s9_a_ff;
   logic signed [37:0] s9_m3_ff;
   logic signed [15:0] s10_raw_ff;
   rsp_type            s11_rsp_ff;

   logic signed [9:0]  rx0s, rx1s, ry0s, ry1s;
   logic signed [35:0] sxe, d1e, d2e;
   logic signed [37:0] sye, dbe;
   logic signed [39:0] t_sum;
   logic signed [32:0] rawe, ampe, gain_prod;

   function automatic logic signed [21:0] dot(logic signed [9:0] p, logic [8:0] ga,
                                              logic signed [9:0] q, logic [8:0] gb);
      logic signed [21:0] pe, qe, ae, be;
      pe = 22'(p);
      qe = 22'(q);
      ae = $signed({13'b0, ga}) - 22'sd256;
      be = $signed({13'b0, gb}) - 22'sd256;
      return (pe * ae) + (qe * be);
   endfunction

   assign en        = !v11_ff || rsp_ready;
   assign rsp_valid = v11_ff;
   assign rsp_data  = s11_rsp_ff;

   assign rx0s = $signed({2'b0, lk.rx0});
   assign ry0s = $signed({2'b0, lk.ry0});
   assign rx1s = rx0s - 10'sd256;
   assign ry1s = ry0s - 10'sd256;

   assign sxe = $signed({24'b0, s6_sx_ff});
   assign d1e = 36'(s6_v1_ff) - 36'(s6_u1_ff);
   assign d2e = 36'(s6_v2_ff) - 36'(s6_u2_ff);
   assign sye = $signed({26'b0, s8_sy_ff});
   assign dbe = 38'(s8_b_ff) - 38'(s8_a_ff);
   assign t_sum = 40'(s9_a_ff) + 40'sd65536 + 40'(s9_m3_ff >>> 12);
   assign rawe = 33'(s10_raw_ff);
   assign ampe = $signed({17'b0, amplitude});
   assign gain_prod = rawe * ampe;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (en) begin
         v6_ff  <= lk.valid;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_u1_ff <= dot(rx0s, lk.g[0], ry0s, lk.g[1]);
         s6_v1_ff <= dot(rx1s, lk.g[2], ry0s, lk.g[3]);
         s6_u2_ff <= dot(rx0s, lk.g[4], ry1s, lk.g[5]);
         s6_v2_ff <= dot(rx1s, lk.g[6], ry1s, lk.g[7]);
         s6_sx_ff <= lk.sx;
         s6_sy_ff <= lk.sy;
         s7_m1_ff <= sxe * d1e;
         s7_m2_ff <= sxe * d2e;
         s7_u1_ff <= s6_u1_ff;
         s7_u2_ff <= s6_u2_ff;
         s7_sy_ff <= s6_sy_ff;
         s8_a_ff  <= 24'(s7_u1_ff) + 24'(s7_m1_ff >>> 12);
         s8_b_ff  <= 24'(s7_u2_ff) + 24'(s7_m2_ff >>> 12);
         s8_sy_ff <= s7_sy_ff;
         s9_m3_ff <= sye * dbe;
         s9_a_ff  <= s8_a_ff;
         // keep bits 19 to 4, then remove the offset
         s10_raw_ff <= $signed(t_sum[19:4] - 16'h1000);
         s11_rsp_ff.raw_noise    <= s10_raw_ff;
         s11_rsp_ff.scaled_noise <= $signed(gain_prod[31:12]);
      end
   end

endmodule

// File: design/fixed_point_gradient_noise_core.sv
// ----------------------------------------------------------------------------
// fixed_point_gradient_noise_core
// One octave of fixed-point 2D gradient noise with loadable tables.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_data  (gpn_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_ready | rsp_data  (gpn_pkg::rsp_type)
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp is not stalled; an evaluate
// result passes through the queue write, then an 11-stage pipe.
// Table writes take effect in order with evaluates; kind 3 is dropped.
// A stalled rsp freezes the whole pipe; the 4-entry queue keeps req open
// until it fills.
// Synchronous active-high reset; tables are not cleared.
// ----------------------------------------------------------------------------
module fixed_point_gradient_noise_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gpn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gpn_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import gpn_pkg::*;

   cfg_type cfg_ff;
   cmd_type head;
   lk_type  lk;
   logic    head_valid, pop, en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_u  <= 32'd0;
         cfg_ff.origin_v  <= 32'd0;
         cfg_ff.step_u    <= 32'd1048576;
         cfg_ff.step_v    <= 32'd1048576;
         cfg_ff.amplitude <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_U:  cfg_ff.origin_u  <= csr_wdata;
            CSR_ORIGIN_V:  cfg_ff.origin_v  <= csr_wdata;
            CSR_STEP_U:    cfg_ff.step_u    <= csr_wdata;
            CSR_STEP_V:    cfg_ff.step_v    <= csr_wdata;
            CSR_AMPLITUDE: cfg_ff.amplitude <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   gpn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   gpn_lookup u_lookup (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .lk         (lk)
   );

   gpn_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .amplitude (cfg_ff.amplitude),
      .lk        (lk),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
